/* rtl/fdg_pkg.sv */
package fdg_pkg;

   // result status codes
   typedef enum logic [2:0] {
      STATUS_IDLE    = 3'd0,
      STATUS_STARTED = 3'd1,
      STATUS_FLOWING = 3'd2,
      STATUS_TRIP    = 3'd3,
      STATUS_TRIPPED = 3'd4,
      STATUS_ENDED   = 3'd5
   } status_type;

   // csr register indexes
   localparam logic [1:0] CSR_LIMIT_SECONDS = 2'd0;
   localparam logic [1:0] CSR_GAP_MILLIS    = 2'd1;

   localparam int TIME_W  = 40;
   localparam int PULSE_W = 16;
   localparam int TOTAL_W = 32;
   localparam int LIMIT_W = 17;
   localparam int GAP_W   = 20;
   localparam int REM_W   = 17;
   // limit in ms, plus round-up slack, fits here
   localparam int LMS_W   = 27;

   localparam logic [9:0] MS_PER_S = 10'd1000;
   localparam logic [9:0] ROUND_UP = 10'd999;

   // floor(n / 1000) == (n * RECIP) >> DIV_SHIFT for every n below 2**27
   localparam logic [27:0] RECIP     = 28'd137438954;
   localparam int          DIV_SHIFT = 37;

   typedef struct packed {
      status_type          status;
      logic [TIME_W-1:0]   elapsed_ms;
      logic [LMS_W-1:0]    rem_num;
      logic [TOTAL_W-1:0]  total_pulses;
   } track_type;

endpackage

/* rtl/flow_duration_guard.sv */
// Flow duration guard: each request is one flow-meter sample (millisecond
// timestamp and new pulse count) and yields exactly one response with the
// flow status, elapsed milliseconds, seconds left before the trip (rounded
// up) and the saturating pulse total of the current or last flow. Requests
// are taken back to back, one per cycle, while rsp_tready does not hold off the
// pipeline, and each response passes three registers: an input register, the
// flow tracker that updates its state and works out the status, and the
// response register behind a reciprocal multiply that divides the remaining
// milliseconds by 1000.
// Write limit_seconds (index 0) and gap_millis (index 1) only while no
// request is in flight; both are 0 after reset.
module flow_duration_guard (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // time_ms[39:0], pulse_count[55:40]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[2:0], elapsed_ms[42:3], remaining_s[59:43], total_pulses[91:60], zero[95:92]
   output logic [95:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [19:0] csr_data
);

   logic [fdg_pkg::LMS_W-1:0]    limit_ms_ff;
   logic [fdg_pkg::GAP_W-1:0]    gap_ff;

   logic                         v1_ff, v1_in;
   logic                         v2_ff, v2_in;
   logic                         v3_ff, v3_in;
   logic                         s1_ready, s2_ready, s3_ready;
   logic                         move1;
   logic                         move2;

   logic [fdg_pkg::TIME_W-1:0]   time_ff;
   logic [fdg_pkg::PULSE_W-1:0]  pulses_ff;
   fdg_pkg::track_type           track;

   logic [54:0]                  quot_prod;
   fdg_pkg::status_type          status_ff;
   logic [fdg_pkg::TIME_W-1:0]   elapsed_ff;
   logic [fdg_pkg::REM_W-1:0]    remaining_ff;
   logic [fdg_pkg::TOTAL_W-1:0]  total_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ms_ff <= '0;
         gap_ff      <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            fdg_pkg::CSR_LIMIT_SECONDS: begin
               limit_ms_ff <= {10'd0, csr_data[fdg_pkg::LIMIT_W-1:0]} *
                              {17'd0, fdg_pkg::MS_PER_S};
            end
            fdg_pkg::CSR_GAP_MILLIS: begin
               gap_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // pipeline handshake: a stage takes new data when empty or draining
   assign s3_ready   = !v3_ff || rsp_tready;
   assign s2_ready   = !v2_ff || s3_ready;
   assign s1_ready   = !v1_ff || s2_ready;
   assign req_tready = s1_ready;
   assign move1      = v1_ff && s2_ready;
   assign move2      = v2_ff && s3_ready;

   always_comb begin
      v1_in = s1_ready ? req_tvalid : v1_ff;
      v2_in = s2_ready ? v1_ff : v2_ff;
      v3_in = s3_ready ? v2_ff : v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && s1_ready) begin
         time_ff   <= req_tdata[39:0];
         pulses_ff <= req_tdata[55:40];
      end
   end

   fdg_tracker u_tracker (
      .clock       (clock),
      .reset       (reset),
      .load        (move1),
      .time_ms     (time_ff),
      .pulse_count (pulses_ff),
      .limit_ms    (limit_ms_ff),
      .gap_millis  (gap_ff),
      .result      (track)
   );

   // divide by 1000 through the reciprocal, exact for this numerator range
   assign quot_prod = {28'd0, track.rem_num} * {27'd0, fdg_pkg::RECIP};

   always_ff @(posedge clock) begin
      if (move2) begin
         status_ff    <= track.status;
         elapsed_ff   <= track.elapsed_ms;
         remaining_ff <= quot_prod[fdg_pkg::DIV_SHIFT +: fdg_pkg::REM_W];
         total_ff     <= track.total_pulses;
      end
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = {4'd0, total_ff, remaining_ff, elapsed_ff, status_ff};

endmodule

/* rtl/fdg_tracker.sv */
module fdg_tracker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  logic [fdg_pkg::TIME_W-1:0]          time_ms,
   input  logic [fdg_pkg::PULSE_W-1:0]         pulse_count,
   input  logic [fdg_pkg::LMS_W-1:0]           limit_ms,
   input  logic [fdg_pkg::GAP_W-1:0]           gap_millis,
   output fdg_pkg::track_type                  result
);

   logic                               flowing_ff, flowing_in;
   logic                               tripped_ff, tripped_in;
   logic [fdg_pkg::TIME_W-1:0]         start_ff, start_in;
   logic [fdg_pkg::TIME_W-1:0]         last_ff, last_in;
   logic [fdg_pkg::TOTAL_W-1:0]        total_ff, total_in;
   fdg_pkg::track_type                 result_ff, result_in;

   logic                               pulses_nz;
   logic                               ended;
   logic [fdg_pkg::TOTAL_W-1:0]        base;
   logic [fdg_pkg::TOTAL_W:0]          sum;
   logic [fdg_pkg::TIME_W:0]           gap_diff;
   logic                               gap_over;
   logic [fdg_pkg::TIME_W:0]           run_diff;
   logic                               run_ge;
   logic [fdg_pkg::TIME_W-1:0]         used;
   logic                               used_ge;
   logic [fdg_pkg::TIME_W-1:0]         end_time;
   logic [fdg_pkg::TIME_W:0]           end_diff;
   fdg_pkg::status_type                status;

   always_comb begin
      flowing_in = flowing_ff;
      tripped_in = tripped_ff;
      start_in   = start_ff;
      last_in    = last_ff;
      total_in   = total_ff;
      ended      = 1'b0;
      base       = total_ff;
      pulses_nz  = |pulse_count;

      gap_diff = {1'b0, time_ms} - {1'b0, last_ff};
      gap_over = !gap_diff[fdg_pkg::TIME_W] &&
                 (gap_diff[fdg_pkg::TIME_W-1:0] > {20'd0, gap_millis});

      if (pulses_nz) begin
         if (!flowing_ff) begin
            flowing_in = 1'b1;
            tripped_in = 1'b0;
            start_in   = time_ms;
            base       = '0;
         end
         last_in = time_ms;
      end else if (flowing_ff && gap_over) begin
         flowing_in = 1'b0;
         ended      = 1'b1;
      end
      sum = {1'b0, base} + {17'd0, pulse_count};
      if (pulses_nz) begin
         total_in = sum[fdg_pkg::TOTAL_W] ? '1 : sum[fdg_pkg::TOTAL_W-1:0];
      end

      run_diff = {1'b0, time_ms} - {1'b0, start_in};
      run_ge   = !run_diff[fdg_pkg::TIME_W];
      used     = run_ge ? run_diff[fdg_pkg::TIME_W-1:0] : '0;
      used_ge  = used >= {13'd0, limit_ms};

      if (ended) begin
         status = fdg_pkg::STATUS_ENDED;
      end else if (!flowing_in) begin
         status = fdg_pkg::STATUS_IDLE;
      end else if (tripped_in) begin
         status = fdg_pkg::STATUS_TRIPPED;
      end else if (run_ge && used_ge) begin
         tripped_in = 1'b1;
         status     = fdg_pkg::STATUS_TRIP;
      end else if (pulses_nz && total_in == {16'd0, pulse_count} && start_in == time_ms) begin
         status = fdg_pkg::STATUS_STARTED;
      end else begin
         status = fdg_pkg::STATUS_FLOWING;
      end

      end_time = flowing_in ? time_ms : last_in;
      end_diff = {1'b0, end_time} - {1'b0, start_in};

      result_in.status       = status;
      result_in.total_pulses = total_in;
      if ((start_in == '0 && !flowing_in) || end_diff[fdg_pkg::TIME_W]) begin
         result_in.elapsed_ms = '0;
      end else begin
         result_in.elapsed_ms = end_diff[fdg_pkg::TIME_W-1:0];
      end
      // numerator of the rounded-up divide; zero when nothing remains
      if (!flowing_in || tripped_in || used_ge) begin
         result_in.rem_num = '0;
      end else begin
         result_in.rem_num = limit_ms - used[fdg_pkg::LMS_W-1:0] +
                             {17'd0, fdg_pkg::ROUND_UP};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flowing_ff <= 1'b0;
         tripped_ff <= 1'b0;
         start_ff   <= '0;
         last_ff    <= '0;
         total_ff   <= '0;
      end else if (load) begin
         flowing_ff <= flowing_in;
         tripped_ff <= tripped_in;
         start_ff   <= start_in;
         last_ff    <= last_in;
         total_ff   <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

/* tb/sv/flow_duration_guard_test.sv */
`timescale 1ns / 100ps

module flow_duration_guard_test;

   localparam longint unsigned MILLIS_PER_SEC = 64'd1000;
   localparam longint unsigned ROUND_UP_MS    = 64'd999;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int NUM_PHASES       = 8;
   localparam int PHASE_SAMPLES    = 240;
   localparam int DRAIN_LIMIT      = 5000;

   typedef struct packed {
      fdg_pkg::status_type                 status;
      logic [fdg_pkg::TIME_W-1:0]          elapsed_ms;
      logic [fdg_pkg::REM_W-1:0]           remaining_s;
      logic [fdg_pkg::TOTAL_W-1:0]         total_pulses;
   } flow_report_type;

   typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type                  kind;
      logic [1:0]                    index;
      logic [19:0]                   value;
      logic [fdg_pkg::TIME_W-1:0]    time_ms;
      logic [fdg_pkg::PULSE_W-1:0]   pulses;
      bit                            typed;
      flow_report_type               want;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;   // time_ms[39:0], pulse_count[55:40]
   logic        rsp_tvalid;
   logic        rsp_tready;
   // status[2:0], elapsed_ms[42:3], remaining_s[59:43], total_pulses[91:60], zero[95:92]
   logic [95:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [19:0] csr_data;

   // predictor copy of the flow state and registers
   bit                            flowing_now;
   bit                            tripped_now;
   logic [fdg_pkg::TIME_W-1:0]    began_ms;
   logic [fdg_pkg::TIME_W-1:0]    recent_pulse_ms;
   logic [fdg_pkg::TOTAL_W-1:0]   pulse_sum;
   logic [fdg_pkg::LIMIT_W-1:0]   limit_s;
   logic [fdg_pkg::GAP_W-1:0]     gap_ms;

   flow_report_type pending_reports[$];
   stim_row_type    stim_rows[$];
   int              err_count;
   bit              tx_gaps_on;
   bit              rx_gaps_on;
   bit              long_hold_due;

   flow_duration_guard u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(40_000_000);
      $display("flow_duration_guard_test: done, errors");
      $finish;
   end

   function automatic logic [fdg_pkg::TIME_W-1:0] since(
         input logic [fdg_pkg::TIME_W-1:0] a, input logic [fdg_pkg::TIME_W-1:0] b);
      return (a > b) ? a - b : '0;
   endfunction

   function automatic flow_report_type predict_sample(
         input logic [fdg_pkg::TIME_W-1:0] now, input logic [fdg_pkg::PULSE_W-1:0] pulses);
      logic [63:0]         sum;
      logic [63:0]         limit_ms;
      logic [63:0]         used;
      logic [63:0]         rem_full;
      fdg_pkg::status_type st;
      bit                  ended;
      flow_report_type     r;
      ended = 1'b0;
      st = fdg_pkg::STATUS_IDLE;
      limit_ms = {47'd0, limit_s} * MILLIS_PER_SEC;
      if (pulses != '0) begin
         if (!flowing_now) begin
            flowing_now = 1'b1;
            tripped_now = 1'b0;
            began_ms = now;
            pulse_sum = '0;
         end
         recent_pulse_ms = now;
         sum = {32'd0, pulse_sum} + {48'd0, pulses};
         pulse_sum = (sum > 64'hFFFF_FFFF) ? '1 : sum[fdg_pkg::TOTAL_W-1:0];
      end else if (flowing_now && since(now, recent_pulse_ms) > {20'd0, gap_ms}) begin
         flowing_now = 1'b0;
         st = fdg_pkg::STATUS_ENDED;
         ended = 1'b1;
      end
      if (!ended) begin
         if (!flowing_now) begin
            st = fdg_pkg::STATUS_IDLE;
         end else if (tripped_now) begin
            st = fdg_pkg::STATUS_TRIPPED;
         end else if (now >= began_ms && {24'd0, now - began_ms} >= limit_ms) begin
            tripped_now = 1'b1;
            st = fdg_pkg::STATUS_TRIP;
         end else if (pulses != '0 && pulse_sum == {16'd0, pulses} && began_ms == now) begin
            st = fdg_pkg::STATUS_STARTED;
         end else begin
            st = fdg_pkg::STATUS_FLOWING;
         end
      end
      r.status = st;
      if (began_ms == '0 && !flowing_now)
         r.elapsed_ms = '0;
      else
         r.elapsed_ms = since(flowing_now ? now : recent_pulse_ms, began_ms);
      used = {24'd0, since(now, began_ms)};
      if (!flowing_now || tripped_now || used >= limit_ms) begin
         r.remaining_s = '0;
      end else begin
         rem_full = (limit_ms - used + ROUND_UP_MS) / MILLIS_PER_SEC;
         r.remaining_s = rem_full[fdg_pkg::REM_W-1:0];
      end
      r.total_pulses = pulse_sum;
      return r;
   endfunction

   function automatic void sample_row(input logic [fdg_pkg::TIME_W-1:0] t,
                                      input logic [fdg_pkg::PULSE_W-1:0] p);
      stim_rows.push_back('{ROW_SAMPLE, 2'd0, 20'd0, t, p, 1'b0, '0});
   endfunction

   function automatic void checked_row(input logic [fdg_pkg::TIME_W-1:0] t,
                                       input logic [fdg_pkg::PULSE_W-1:0] p,
                                       input flow_report_type want);
      stim_rows.push_back('{ROW_SAMPLE, 2'd0, 20'd0, t, p, 1'b1, want});
   endfunction

   function automatic void write_row(input logic [1:0] idx, input logic [19:0] val);
      stim_rows.push_back('{ROW_WRITE, idx, val, '0, '0, 1'b0, '0});
   endfunction

   // called and returns at a falling edge
   task automatic send_sample(input logic [fdg_pkg::TIME_W-1:0] t,
                              input logic [fdg_pkg::PULSE_W-1:0] p,
                              input bit typed, input flow_report_type want);
      int unsigned     pause;
      flow_report_type got;
      pause = tx_gaps_on ? $urandom_range(0, 5) : 0;
      if (pause > 0) begin
         req_tvalid <= 1'b0;
         repeat (pause) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {p, t};
      do @(posedge clock); while (!req_tready);
      got = predict_sample(t, p);
      pending_reports.push_back(typed ? want : got);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [19:0] val);
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == fdg_pkg::CSR_LIMIT_SECONDS)
         limit_s = val[fdg_pkg::LIMIT_W-1:0];
      else if (idx == fdg_pkg::CSR_GAP_MILLIS)
         gap_ms = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // response side
   initial begin
      int unsigned     hold;
      flow_report_type want;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         hold = rx_gaps_on ? $urandom_range(0, 5) : 0;
         if (long_hold_due) begin
            hold = LONG_HOLD_CYCLES;
            long_hold_due = 1'b0;
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (pending_reports.size() == 0) begin
            $error("unexpected response, tdata %h", rsp_tdata);
            err_count++;
         end else begin
            want = pending_reports.pop_front();
            if (rsp_tdata[2:0] !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tdata[2:0]);
               err_count++;
            end
            if (rsp_tdata[42:3] !== want.elapsed_ms) begin
               $error("elapsed_ms: expected %0d, got %0d", want.elapsed_ms, rsp_tdata[42:3]);
               err_count++;
            end
            if (rsp_tdata[59:43] !== want.remaining_s) begin
               $error("remaining_s: expected %0d, got %0d", want.remaining_s, rsp_tdata[59:43]);
               err_count++;
            end
            if (rsp_tdata[91:60] !== want.total_pulses) begin
               $error("total_pulses: expected %0d, got %0d", want.total_pulses,
                      rsp_tdata[91:60]);
               err_count++;
            end
            if (rsp_tdata[95:92] !== 4'd0) begin
               $error("pad: expected 0, got %0d", rsp_tdata[95:92]);
               err_count++;
            end
         end
         @(negedge clock);
      end
   end

   // request side
   initial begin
      logic [fdg_pkg::TIME_W-1:0]  sample_ms;
      logic [fdg_pkg::TIME_W-1:0]  back_ms;
      logic [fdg_pkg::PULSE_W-1:0] pulses;
      logic [fdg_pkg::LIMIT_W-1:0] lim;
      logic [fdg_pkg::GAP_W-1:0]   gap;
      int unsigned                 limit_ms;
      int unsigned                 draw;
      int unsigned                 waited;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      err_count = 0;
      tx_gaps_on = 1'b1;
      rx_gaps_on = 1'b1;
      long_hold_due = 1'b0;
      flowing_now = 1'b0;
      tripped_now = 1'b0;
      began_ms = '0;
      recent_pulse_ms = '0;
      pulse_sum = '0;
      limit_s = '0;
      gap_ms = '0;

      // reset registers: zero limit trips at once, zero gap ends on any later silence
      checked_row(40'd0, 16'd0, '{fdg_pkg::STATUS_IDLE, 40'd0, 17'd0, 32'd0});
      checked_row(40'd10, 16'd1, '{fdg_pkg::STATUS_TRIP, 40'd0, 17'd0, 32'd1});
      checked_row(40'd10, 16'd0, '{fdg_pkg::STATUS_TRIPPED, 40'd0, 17'd0, 32'd1});
      checked_row(40'd11, 16'd0, '{fdg_pkg::STATUS_ENDED, 40'd0, 17'd0, 32'd1});
      checked_row(40'd12, 16'd0, '{fdg_pkg::STATUS_IDLE, 40'd0, 17'd0, 32'd1});
      write_row(fdg_pkg::CSR_LIMIT_SECONDS, 20'd2);
      write_row(fdg_pkg::CSR_GAP_MILLIS, 20'd500);
      sample_row(40'd1000, 16'hFFFF);
      sample_row(40'd1500, 16'd0);
      sample_row(40'd900, 16'd0);
      sample_row(40'd2999, 16'd1);
      sample_row(40'd3000, 16'd0);
      sample_row(40'd3499, 16'd0);
      sample_row(40'd3500, 16'd0);
      sample_row(40'd3600, 16'd7);
      write_row(fdg_pkg::CSR_LIMIT_SECONDS, 20'd86400);
      write_row(fdg_pkg::CSR_GAP_MILLIS, 20'd600000);
      sample_row(40'd603600, 16'd0);
      sample_row(40'd603601, 16'd0);
      checked_row(40'hFF_FFFF_FFFF, 16'hFFFF,
                  '{fdg_pkg::STATUS_STARTED, 40'd0, 17'd86400, 32'd65535});
      sample_row(40'hFF_FFFF_FFFF, 16'hFFFF);
      sample_row(40'd0, 16'd0);
      write_row(fdg_pkg::CSR_LIMIT_SECONDS, 20'd1);
      write_row(fdg_pkg::CSR_GAP_MILLIS, 20'd0);
      sample_row(40'hFF_FFFF_FFFF, 16'd0);
      sample_row(40'd0, 16'd5);

      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_WRITE)
            csr_write(stim_rows[i].index, stim_rows[i].value);
         else
            send_sample(stim_rows[i].time_ms, stim_rows[i].pulses,
                        stim_rows[i].typed, stim_rows[i].want);
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: begin lim = 17'd0; gap = 20'd0; end
            1: begin lim = 17'd86400; gap = 20'd600000; end
            2: begin lim = 17'd1; gap = 20'd0; end
            3: begin
               lim = 17'($urandom_range(0, 86400));
               gap = 20'($urandom_range(0, 600000));
            end
            default: begin
               lim = 17'($urandom_range(1, 12));
               gap = 20'($urandom_range(0, 2500));
            end
         endcase
         csr_write(fdg_pkg::CSR_LIMIT_SECONDS, {3'd0, lim});
         csr_write(fdg_pkg::CSR_GAP_MILLIS, gap);
         tx_gaps_on = (ph != 5);
         rx_gaps_on = (ph != 5);
         if (ph == 4)
            long_hold_due = 1'b1;
         limit_ms = 32'(lim) * 32'd1000;
         sample_ms = {8'($urandom_range(0, 255)), 32'($urandom)};
         if (sample_ms > 40'hF0_0000_0000)
            sample_ms -= 40'h10_0000_0000;
         for (int n = 0; n < PHASE_SAMPLES; n++) begin
            draw = $urandom_range(0, 99);
            if (draw < 60)
               sample_ms += 40'($urandom_range(0, gap));
            else if (draw < 85)
               sample_ms += 40'($urandom_range(0, 2 * gap + 2));
            else if (draw < 95)
               sample_ms += 40'($urandom_range(limit_ms / 2, limit_ms + 1000));
            draw = $urandom_range(0, 99);
            if (draw < 40)
               pulses = '0;
            else if (draw < 85)
               pulses = 16'($urandom_range(1, 20));
            else if (draw < 95)
               pulses = 16'($urandom_range(0, 65535));
            else
               pulses = 16'hFFFF;
            // now and then a sample from the past
            if ($urandom_range(0, 99) < 4) begin
               draw = $urandom_range(1, 5000);
               back_ms = (sample_ms > 40'(draw)) ? sample_ms - 40'(draw) : '0;
               send_sample(back_ms, pulses, 1'b0, '0);
            end else begin
               send_sample(sample_ms, pulses, 1'b0, '0);
            end
         end
      end

      req_tvalid <= 1'b0;
      waited = 0;
      while (pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (8) @(negedge clock);
      if (pending_reports.size() != 0) begin
         $error("%0d responses never arrived", pending_reports.size());
         err_count++;
      end
      if (err_count == 0)
         $display("flow_duration_guard_test: done, clean");
      else
         $display("flow_duration_guard_test: done, errors");
      $finish;
   end

endmodule
